[rtl/stmpq_pkg.sv]
// Shared types and constants for the slot-table minimum priority queue.
`default_nettype none

package stmpq_pkg;

    localparam int NODE_BITS    = 8;
    localparam int IO_KEY_BITS  = 16;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_UPDATE = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_SCAN = 2'd1,
        SEQ_TAIL = 2'd2
    } seq_state_t;

    typedef struct packed {
        action_t                  action;
        logic [NODE_BITS-1:0]     node_id;
        logic [IO_KEY_BITS-1:0]   key_major;
        logic [IO_KEY_BITS-1:0]   key_minor;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic                     node_present;
        logic                     top_valid;
        logic [NODE_BITS-1:0]     top_node;
        logic [IO_KEY_BITS-1:0]   top_major;
        logic [IO_KEY_BITS-1:0]   top_minor;
    } rsp_t;

    // Sequencer to datapath control group.
    typedef struct packed {
        logic accept;     // command transfer this cycle
        logic rd_en;      // issue a memory read this cycle
        logic data_vld;   // read data from the previous cycle is present
        logic data_last;  // that read data is the last slot
    } seq_ctl_t;

endpackage

`default_nettype wire

[rtl/stmpq_ram.sv]
// Slot memory: one write port, one read port, registered read data.
`default_nettype none

module stmpq_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/stmpq_seq.sv]
// Scan sequencer: walks the read address over all slots once per command.
`default_nettype none

module stmpq_seq #(
    parameter int SLOTS = 64,
    parameter int AW    = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output stmpq_pkg::seq_ctl_t ctl,
    output logic [AW-1:0]       rd_addr,
    output logic [AW-1:0]       data_idx
);
    import stmpq_pkg::*;

    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);

    seq_state_t    state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          vld_reg, vld_next;
    logic          last_reg, last_next;
    logic          accept;
    logic          rd_en;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE: if (start) state_next = SEQ_SCAN;
            SEQ_SCAN: if (addr_reg == LAST_ADDR) state_next = SEQ_TAIL;
            SEQ_TAIL: state_next = SEQ_IDLE;
            default:  state_next = SEQ_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        accept = 1'b0;
        rd_en  = 1'b0;
        busy   = 1'b1;
        case (state_reg)
            SEQ_IDLE:
            begin
                busy   = 1'b0;
                accept = start;
            end
            SEQ_SCAN: rd_en = 1'b1;
            SEQ_TAIL: rd_en = 1'b0;
            default:  busy  = 1'b0;
        endcase
    end

    always_comb
    begin
        addr_next = addr_reg;
        if (accept)
        begin
            addr_next = '0;
        end
        else if (rd_en)
        begin
            addr_next = addr_reg + 1'b1;
        end
        idx_next  = addr_reg;
        vld_next  = rd_en;
        last_next = rd_en && (addr_reg == LAST_ADDR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            addr_reg  <= '0;
            vld_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            vld_reg   <= vld_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    assign rd_addr       = addr_reg;
    assign data_idx      = idx_reg;
    assign ctl.accept    = accept;
    assign ctl.rd_en     = rd_en;
    assign ctl.data_vld  = vld_reg;
    assign ctl.data_last = last_reg;

endmodule

`default_nettype wire

[rtl/slot_table_min_priority_queue_core.sv]
// Top level of the slot-table minimum priority queue.
// A new start is taken in the done cycle; no command is taken while a scan runs.
// The scan is paced by the single read port of the slot memory, read once per slot.
// Reset clears all used marks (empty table); node and key storage is not cleared.
// The result is flagged by a one-cycle done strobe and held until the next one; the receiver cannot stall it.
`default_nettype none

module slot_table_min_priority_queue_core #(
    parameter int SLOTS    = 64,
    parameter int KEY_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  stmpq_pkg::req_t req,
    output logic            busy,
    output logic            done,
    output stmpq_pkg::rsp_t rsp
);
    import stmpq_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WW = NODE_BITS + 2 * KEY_BITS;
    localparam logic [KEY_BITS-1:0] KEY_INF = {KEY_BITS{1'b1}};

    seq_ctl_t      ctl;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] data_idx;
    logic [WW-1:0] rdata;
    logic          mem_we;
    logic [WW-1:0] mem_wdata;

    // Command, used marks and the running fold over the scan.
    req_t                 cmd_reg, cmd_next;
    logic [SLOTS-1:0]     used_reg, used_next;
    logic                 hit_reg, hit_next;
    logic                 present_reg, present_next;
    logic                 tvalid_reg, tvalid_next;
    logic [NODE_BITS-1:0] tnode_reg, tnode_next;
    logic [KEY_BITS-1:0]  tmaj_reg, tmaj_next;
    logic [KEY_BITS-1:0]  tmin_reg, tmin_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 done_reg, done_next;

    // Per-slot view after the action has been applied.
    logic [NODE_BITS-1:0] slot_node;
    logic [KEY_BITS-1:0]  slot_maj;
    logic [KEY_BITS-1:0]  slot_min;
    logic [KEY_BITS-1:0]  new_maj;
    logic [KEY_BITS-1:0]  new_min;
    logic                 slot_used;
    logic                 is_ins, is_upd, is_rem;
    logic                 match, take;
    logic                 eff_used;
    logic [NODE_BITS-1:0] eff_node;
    logic [KEY_BITS-1:0]  eff_maj;
    logic [KEY_BITS-1:0]  eff_min;
    logic                 better;

    stmpq_seq #(
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .ctl      (ctl),
        .rd_addr  (rd_addr),
        .data_idx (data_idx)
    );

    // Node and key of each slot; the write hits the slot whose data is in hand,
    // while the read is already one slot ahead, so the two never collide.
    stmpq_ram #(
        .WIDTH (WW),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (data_idx),
        .wdata (mem_wdata),
        .re    (ctl.rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    assign {slot_node, slot_maj, slot_min} = rdata;

    // Narrow or widen the key inputs to the stored key width.
    assign new_maj = KEY_BITS'(cmd_reg.key_major);
    assign new_min = KEY_BITS'(cmd_reg.key_minor);

    assign is_ins    = (cmd_reg.action == ACT_INSERT);
    assign is_upd    = (cmd_reg.action == ACT_UPDATE);
    assign is_rem    = (cmd_reg.action == ACT_REMOVE);
    assign slot_used = used_reg[data_idx];

    // Insert targets the first free slot; update and remove the first used
    // slot that holds the node. Only the first match along the scan is taken.
    always_comb
    begin
        match = 1'b0;
        if (is_ins)
        begin
            match = !slot_used;
        end
        else if (is_upd || is_rem)
        begin
            match = slot_used && (slot_node == cmd_reg.node_id);
        end
        take = ctl.data_vld && match && !hit_reg;

        eff_used = slot_used;
        eff_node = slot_node;
        eff_maj  = slot_maj;
        eff_min  = slot_min;
        if (take && is_ins)
        begin
            eff_used = 1'b1;
            eff_node = cmd_reg.node_id;
        end
        if (take && is_rem)
        begin
            eff_used = 1'b0;
        end
        if (take && (is_ins || is_upd))
        begin
            eff_maj = new_maj;
            eff_min = new_min;
        end

        // Strictly below the running best keeps the lowest slot on ties.
        better = eff_used && ({eff_maj, eff_min} < {tmaj_reg, tmin_reg});
    end

    assign mem_we    = take && (is_ins || is_upd);
    assign mem_wdata = {eff_node, eff_maj, eff_min};

    always_comb
    begin
        cmd_next     = cmd_reg;
        used_next    = used_reg;
        hit_next     = hit_reg;
        present_next = present_reg;
        tvalid_next  = tvalid_reg;
        tnode_next   = tnode_reg;
        tmaj_next    = tmaj_reg;
        tmin_next    = tmin_reg;
        rsp_next     = rsp_reg;
        done_next    = 1'b0;

        if (ctl.accept)
        begin
            // Latch the command and reset the fold to "no minimum".
            cmd_next     = req;
            hit_next     = 1'b0;
            present_next = 1'b0;
            tvalid_next  = 1'b0;
            tnode_next   = '0;
            tmaj_next    = KEY_INF;
            tmin_next    = KEY_INF;
        end
        else if (ctl.data_vld)
        begin
            if (take)
            begin
                hit_next = 1'b1;
                if (is_ins || is_rem)
                begin
                    used_next[data_idx] = eff_used;
                end
            end
            if (eff_used && (eff_node == cmd_reg.node_id))
            begin
                present_next = 1'b1;
            end
            if (better)
            begin
                tvalid_next = 1'b1;
                tnode_next  = eff_node;
                tmaj_next   = eff_maj;
                tmin_next   = eff_min;
            end

            // Last slot folded: load the result from the final fold values.
            if (ctl.data_last)
            begin
                done_next = 1'b1;
                rsp_next.status = ST_OK;
                if (!hit_next && is_ins)
                begin
                    rsp_next.status = ST_FULL;
                end
                else if (!hit_next && (is_upd || is_rem))
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
                rsp_next.node_present = present_next;
                rsp_next.top_valid    = tvalid_next;
                rsp_next.top_node     = tnode_next;
                rsp_next.top_major    = IO_KEY_BITS'(tmaj_next);
                rsp_next.top_minor    = IO_KEY_BITS'(tmin_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        hit_reg     <= hit_next;
        present_reg <= present_next;
        tvalid_reg  <= tvalid_next;
        tnode_reg   <= tnode_next;
        tmaj_reg    <= tmaj_next;
        tmin_reg    <= tmin_next;
        rsp_reg     <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

[rtl/stmpq_checker.sv]
// Port-level checks for the slot-table minimum priority queue, bound to the top level.
`default_nettype none

module stmpq_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            done,
    input stmpq_pkg::rsp_t rsp
);
    import stmpq_pkg::*;

    // A command transfer starts a scan.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    // Every finished scan delivers its result as busy drops.
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("scan ended without a result strobe");

    // A result strobe lasts exactly one cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // With no qualifying minimum the reported node is zero.
    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.top_valid) |-> (rsp.top_node == '0))
        else $error("top node set without a valid minimum");

    // A node that was not found is absent afterwards.
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (rsp.status == ST_NOT_FOUND)) |-> !rsp.node_present)
        else $error("node reported present after not-found");

endmodule

bind slot_table_min_priority_queue_core stmpq_checker u_stmpq_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire
